// ===== rtl/mlft_pkg.sv =====
// Shared types and constants for the MAC learning forwarding table.
package mlft_pkg;

  localparam int unsigned MAC_W   = 48;
  localparam int unsigned PORT_W  = 4;
  localparam int unsigned MASK_W  = 16;
  localparam int unsigned PCNT_W  = 5;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 3;

  // Register word indexes on the configuration port.
  localparam logic REG_NPORTS = 1'b0;

  localparam logic [PCNT_W-1:0] NPORTS_RST = 5'd16;

  // Frame sequencing states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_LEARN
  } state_e;

  // Command broadcast to every cell of the table.
  typedef struct packed {
    logic              match_en;
    logic              learn_en;
    logic              any_src;
    logic [MAC_W-1:0]  cmp_src;
    logic [MAC_W-1:0]  cmp_dst;
    logic [MAC_W-1:0]  wr_mac;
    logic [PORT_W-1:0] wr_port;
  } cell_cmd_t;

  // Status that each cell reports.
  typedef struct packed {
    logic              used;
    logic              src_hit;
    logic              dst_hit;
    logic [PORT_W-1:0] port;
  } cell_stat_t;

  // Miss result of the flood logic.
  typedef struct packed {
    logic [PORT_W-1:0] egress_port;
    logic              egress_valid;
    logic [MASK_W-1:0] flood_mask;
  } flood_t;

endpackage

// ===== rtl/mlft_if.sv =====
// Handshake channels for frame headers and forwarding results.
interface mlft_hdr_if;
  import mlft_pkg::*;

  logic              valid;
  logic              ready;
  logic [MAC_W-1:0]  src_mac;
  logic [MAC_W-1:0]  dst_mac;
  logic [PORT_W-1:0] in_port;

  modport source (output valid, src_mac, dst_mac, in_port, input ready);
  modport sink   (input valid, src_mac, dst_mac, in_port, output ready);
endinterface

interface mlft_res_if;
  import mlft_pkg::*;

  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] egress_port;
  logic              egress_valid;
  logic              table_hit;
  logic [MASK_W-1:0] flood_mask;

  modport source (output valid, egress_port, egress_valid, table_hit, flood_mask,
                  input ready);
  modport sink   (input valid, egress_port, egress_valid, table_hit, flood_mask,
                  output ready);
endinterface

// ===== rtl/mlft_cell.sv =====
// One table entry: stored MAC and port, match flags and append logic.
module mlft_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  mlft_pkg::cell_cmd_t  cmd_i,
  input  logic                 prev_used_i,
  output mlft_pkg::cell_stat_t stat_o
);
  import mlft_pkg::*;

  logic              used_q, used_d;
  logic              src_hit_q, dst_hit_q;
  logic [MAC_W-1:0]  mac_q;
  logic [PORT_W-1:0] port_q;
  logic              append;

  // The first free cell after a used neighbor takes a new entry.
  assign append = cmd_i.learn_en && !cmd_i.any_src && !used_q && prev_used_i;

  always_comb begin
    used_d = used_q;
    if (append) begin
      used_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  // Match flags against the table contents before this frame's learn.
  always_ff @(posedge clk_i) begin
    if (cmd_i.match_en) begin
      src_hit_q <= used_q && (mac_q == cmd_i.cmp_src);
      dst_hit_q <= used_q && (mac_q == cmd_i.cmp_dst);
    end
  end

  // Entry write: port refresh on a source hit, full write on append.
  always_ff @(posedge clk_i) begin
    if (append) begin
      mac_q  <= cmd_i.wr_mac;
      port_q <= cmd_i.wr_port;
    end else if (cmd_i.learn_en && cmd_i.any_src && src_hit_q) begin
      port_q <= cmd_i.wr_port;
    end
  end

  assign stat_o.used    = used_q;
  assign stat_o.src_hit = src_hit_q;
  assign stat_o.dst_hit = dst_hit_q;
  assign stat_o.port    = port_q;

endmodule

// ===== rtl/mlft_flood.sv =====
// Flood set and representative egress for a lookup miss.
module mlft_flood #(
  parameter int unsigned MAX_PORTS = 16
) (
  input  logic [mlft_pkg::PCNT_W-1:0] nports_i,
  input  logic [mlft_pkg::PORT_W-1:0] in_port_i,
  output mlft_pkg::flood_t            flood_o
);
  import mlft_pkg::*;

  localparam int unsigned ACT_W = $clog2(MAX_PORTS + 1);

  logic [ACT_W-1:0] active;
  logic [63:0]      mask_wide;

  // Active ports, clamped to the number the switch has.
  always_comb begin
    if (32'(nports_i) > MAX_PORTS) begin
      active = ACT_W'(MAX_PORTS);
    end else begin
      active = ACT_W'(nports_i);
    end
  end

  // Every active port except the ingress port gets a copy.
  always_comb begin
    mask_wide = '0;
    for (int p = 0; p < MAX_PORTS && p < 64; p++) begin
      mask_wide[p] = (p < int'(active)) && (p != int'(in_port_i));
    end
  end

  // Lowest flood port is port 0, or port 1 when port 0 is the ingress.
  always_comb begin
    flood_o.flood_mask = mask_wide[MASK_W-1:0];
    if (in_port_i != '0) begin
      flood_o.egress_valid = (active >= ACT_W'(1));
      flood_o.egress_port  = '0;
    end else begin
      flood_o.egress_valid = (active >= ACT_W'(2));
      flood_o.egress_port  = PORT_W'(1);
    end
    if (!flood_o.egress_valid) begin
      flood_o.egress_port = '0;
    end
  end

endmodule

// ===== rtl/mac_learning_forward_table_top.sv =====
// Top level of the MAC learning forwarding table.
//
//   channel   dir  beat contents
//   frame_i   in   src_mac, dst_mac, in_port
//   result_o  out  egress_port, egress_valid, table_hit, flood_mask
//   apb       in   active port count register at byte address 0
//
// For each frame, the accept cycle compares both MACs in every cell at once;
// the learn state then reduces the cell flags, learns and loads the result
// register. A new frame is taken in the cycle after the learn.
// A full result register that is not drained holds the learn cycle.
// Reset empties the table at once through the per-cell used flags.
module mac_learning_forward_table_top #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned MAX_PORTS     = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  mlft_hdr_if.sink                      frame_i,
  mlft_res_if.source                    result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mlft_pkg::APB_AW-1:0]   paddr,
  input  logic [mlft_pkg::APB_DW-1:0]   pwdata,
  output logic [mlft_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import mlft_pkg::*;

  state_e            state_q, state_d;
  logic [PCNT_W-1:0] nports_q;
  logic [MAC_W-1:0]  src_q, dst_q;
  logic [PORT_W-1:0] inp_q;

  logic              out_valid_q, out_valid_d;
  logic [PORT_W-1:0] out_port_q;
  logic              out_evalid_q, out_hit_q;
  logic [MASK_W-1:0] out_mask_q;

  logic              accept, out_free, learn;
  cell_cmd_t         cmd;
  cell_stat_t        stat [TABLE_ENTRIES];
  logic              any_src, any_dst, full, hit;
  logic [PORT_W-1:0] dst_port, hit_port;
  flood_t            flood;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nports_q <= NPORTS_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_NPORTS) begin
      nports_q <= pwdata[PCNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NPORTS) begin
      prdata = APB_DW'(nports_q);
    end
  end

  // Handshakes.
  assign frame_i.ready = (state_q == ST_IDLE);
  assign accept        = frame_i.valid && frame_i.ready;
  assign out_free      = !out_valid_q || result_o.ready;

  // Sequencer: idle until a beat, then a learn state that waits for a free result register.
  always_comb begin
    state_d = state_q;
    learn   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_LEARN;
        end
      end
      ST_LEARN: begin
        if (out_free) begin
          learn   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Header capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q <= frame_i.src_mac;
      dst_q <= frame_i.dst_mac;
      inp_q <= frame_i.in_port;
    end
  end

  // Command broadcast to the cells.
  always_comb begin
    cmd.match_en = accept;
    cmd.learn_en = learn;
    cmd.any_src  = any_src;
    cmd.cmp_src  = frame_i.src_mac;
    cmd.cmp_dst  = frame_i.dst_mac;
    cmd.wr_mac   = src_q;
    cmd.wr_port  = inp_q;
  end

  // Row of cells; the used flag passes along to find the append slot.
  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    logic prev_used;
    if (i == 0) begin : g_first
      assign prev_used = 1'b1;
    end else begin : g_next
      assign prev_used = stat[i-1].used;
    end
    mlft_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .prev_used_i (prev_used),
      .stat_o      (stat[i])
    );
  end

  // Reduce the match flags; MACs are unique, so at most one cell hits.
  always_comb begin
    any_src  = 1'b0;
    any_dst  = 1'b0;
    dst_port = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      any_src  = any_src | stat[i].src_hit;
      any_dst  = any_dst | stat[i].dst_hit;
      dst_port = dst_port | (stat[i].port & {PORT_W{stat[i].dst_hit}});
    end
  end

  assign full = stat[TABLE_ENTRIES-1].used;

  // The lookup sees this frame's learn: same MAC hits unless the learn dropped.
  always_comb begin
    if (src_q == dst_q) begin
      hit      = any_src || !full;
      hit_port = inp_q;
    end else begin
      hit      = any_dst;
      hit_port = dst_port;
    end
  end

  mlft_flood #(
    .MAX_PORTS (MAX_PORTS)
  ) u_flood (
    .nports_i     (nports_q),
    .in_port_i    (inp_q),
    .flood_o      (flood)
  );

  // Result register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (learn) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (learn) begin
      out_hit_q <= hit;
      if (hit) begin
        out_port_q   <= hit_port;
        out_evalid_q <= 1'b1;
        out_mask_q   <= '0;
      end else begin
        out_port_q   <= flood.egress_port;
        out_evalid_q <= flood.egress_valid;
        out_mask_q   <= flood.flood_mask;
      end
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.egress_port  = out_port_q;
  assign result_o.egress_valid = out_evalid_q;
  assign result_o.table_hit    = out_hit_q;
  assign result_o.flood_mask   = out_mask_q;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the MAC learning forwarding table top level.
module tb;
  import mlft_pkg::*;

  localparam int unsigned FDB_DEPTH   = 64;
  localparam int unsigned PORT_LIMIT  = 16;
  localparam int unsigned MAC_POOL_SZ = 96;
  localparam int unsigned PHASE_BEATS = 250;
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int unsigned HOLD_AT     = 400;
  localparam int unsigned HOLD_CYCLES = 300;

  localparam logic [APB_AW-1:0] NPORTS_ADDR = APB_AW'({REG_NPORTS, 2'b00});

  localparam logic [MAC_W-1:0] MAC_A    = 48'h0011_2233_4455;
  localparam logic [MAC_W-1:0] MAC_B    = 48'h0066_7788_99AA;
  localparam logic [MAC_W-1:0] MAC_C    = 48'h0200_0000_0001;
  localparam logic [MAC_W-1:0] MAC_D    = 48'h0200_0000_0002;
  localparam logic [MAC_W-1:0] MAC_E    = 48'h8000_0000_0000;
  localparam logic [MAC_W-1:0] MAC_F    = 48'h0000_0000_8000;
  localparam logic [MAC_W-1:0] MAC_ZERO = 48'h0000_0000_0000;
  localparam logic [MAC_W-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [MAC_W-1:0] MAC_ALT1 = 48'hAAAA_AAAA_AAAA;
  localparam logic [MAC_W-1:0] MAC_ALT0 = 48'h5555_5555_5555;

  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic [PORT_W-1:0] in_port;
  } frame_t;

  typedef struct packed {
    logic [PORT_W-1:0] egress_port;
    logic              egress_valid;
    logic              table_hit;
    logic [MASK_W-1:0] flood_mask;
  } fwd_result_t;

  // One directed frame: port count to run it under, the header and, where
  // it is obvious, the forwarding decision typed in by hand.
  typedef struct packed {
    logic [PCNT_W-1:0] pcnt;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] inp;
    logic              typed;
    logic [PORT_W-1:0] eport;
    logic              evalid;
    logic              hit;
    logic [MASK_W-1:0] mask;
  } dir_row_t;

  localparam int unsigned N_DIRECTED = 19;
  localparam dir_row_t DIRECTED [N_DIRECTED] = '{
    // Empty table: miss floods all but ingress, then learned ports hit.
    '{5'd16, MAC_A,    MAC_B,    4'd0,  1'b1, 4'd1,  1'b1, 1'b0, 16'hFFFE},
    '{5'd16, MAC_B,    MAC_A,    4'd5,  1'b1, 4'd0,  1'b1, 1'b1, 16'h0000},
    // Relearn of a known source is seen by the lookup in the same frame.
    '{5'd16, MAC_A,    MAC_A,    4'd15, 1'b1, 4'd15, 1'b1, 1'b1, 16'h0000},
    '{5'd16, MAC_ONES, MAC_ZERO, 4'd15, 1'b1, 4'd0,  1'b1, 1'b0, 16'h7FFF},
    '{5'd16, MAC_ZERO, MAC_ONES, 4'd0,  1'b1, 4'd15, 1'b1, 1'b1, 16'h0000},
    '{5'd16, MAC_ZERO, MAC_ZERO, 4'd7,  1'b1, 4'd7,  1'b1, 1'b1, 16'h0000},
    // No other active port: nothing to forward to.
    '{5'd0,  MAC_C,    MAC_D,    4'd0,  1'b1, 4'd0,  1'b0, 1'b0, 16'h0000},
    '{5'd1,  MAC_C,    MAC_D,    4'd0,  1'b1, 4'd0,  1'b0, 1'b0, 16'h0000},
    // Ingress beyond the active ports floods every active port.
    '{5'd1,  MAC_C,    MAC_D,    4'd3,  1'b1, 4'd0,  1'b1, 1'b0, 16'h0001},
    '{5'd2,  MAC_C,    MAC_D,    4'd0,  1'b1, 4'd1,  1'b1, 1'b0, 16'h0002},
    '{5'd2,  MAC_C,    MAC_D,    4'd1,  1'b1, 4'd0,  1'b1, 1'b0, 16'h0001},
    // Port count above the port limit is clamped.
    '{5'd31, MAC_C,    MAC_D,    4'd4,  1'b1, 4'd0,  1'b1, 1'b0, 16'hFFEF},
    '{5'd17, MAC_C,    MAC_D,    4'd0,  1'b1, 4'd1,  1'b1, 1'b0, 16'hFFFE},
    '{5'd16, MAC_ALT1, MAC_ALT0, 4'd15, 1'b1, 4'd0,  1'b1, 1'b0, 16'h7FFF},
    '{5'd16, MAC_ALT0, MAC_ALT1, 4'd10, 1'b1, 4'd15, 1'b1, 1'b1, 16'h0000},
    '{5'd9,  MAC_E,    MAC_F,    4'd12, 1'b0, 4'd0,  1'b0, 1'b0, 16'h0000},
    '{5'd9,  MAC_F,    MAC_C,    4'd3,  1'b0, 4'd0,  1'b0, 1'b0, 16'h0000},
    '{5'd9,  MAC_E,    MAC_F,    4'd8,  1'b0, 4'd0,  1'b0, 1'b0, 16'h0000},
    '{5'd16, MAC_D,    MAC_E,    4'd2,  1'b0, 4'd0,  1'b0, 1'b0, 16'h0000}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  mlft_hdr_if frame_if ();
  mlft_res_if res_if ();

  mac_learning_forward_table_top i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Clock with a period of 8.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Forwarding database as the testbench sees it.
  logic [MAC_W-1:0]  fdb_mac [FDB_DEPTH];
  logic [PORT_W-1:0] fdb_port [FDB_DEPTH];
  int unsigned       fdb_count;
  logic [PCNT_W-1:0] nports_q;

  fwd_result_t       fwd_expected_q [$];
  logic [MAC_W-1:0]  mac_pool [MAC_POOL_SZ];
  int unsigned       n_mismatch;
  int unsigned       n_results;
  int unsigned       n_cycles;
  int unsigned       frame_burst;

  // Learn the source, then look up the destination, flooding on a miss.
  function automatic fwd_result_t forward_frame(frame_t f);
    fwd_result_t r;
    bit          known;
    int unsigned active;
    r     = '0;
    known = 1'b0;
    for (int unsigned i = 0; i < fdb_count; i++) begin
      if (fdb_mac[i] == f.src_mac) begin
        fdb_port[i] = f.in_port;
        known       = 1'b1;
        break;
      end
    end
    if (!known && fdb_count < FDB_DEPTH) begin
      fdb_mac[fdb_count]  = f.src_mac;
      fdb_port[fdb_count] = f.in_port;
      fdb_count++;
    end
    for (int unsigned i = 0; i < fdb_count; i++) begin
      if (fdb_mac[i] == f.dst_mac) begin
        r.egress_port  = fdb_port[i];
        r.egress_valid = 1'b1;
        r.table_hit    = 1'b1;
        return r;
      end
    end
    active = (nports_q > PORT_LIMIT) ? PORT_LIMIT : nports_q;
    for (int unsigned p = 0; p < active; p++) begin
      if (p != f.in_port) begin
        if (!r.egress_valid) begin
          r.egress_port  = PORT_W'(p);
          r.egress_valid = 1'b1;
        end
        r.flood_mask[p] = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    if (n_mismatch < 10) $display("%t: %s", $realtime, msg);
    n_mismatch++;
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // Mostly addresses from a fixed pool so that lookups hit and the table
  // fills, with fresh random addresses mixed in.
  function automatic frame_t random_frame();
    frame_t f;
    f.src_mac = ($urandom_range(0, 99) < 80) ?
                mac_pool[$urandom_range(0, MAC_POOL_SZ - 1)] : random_mac();
    f.dst_mac = ($urandom_range(0, 99) < 70) ?
                mac_pool[$urandom_range(0, MAC_POOL_SZ - 1)] : random_mac();
    f.in_port = PORT_W'($urandom);
    return f;
  endfunction

  // Idle cycles before the next frame: mostly none or short, a few long,
  // and now and then a back-to-back burst.
  function automatic int unsigned frame_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (frame_burst > 0) begin
      frame_burst--;
      return 0;
    end
    if (r < 5) begin
      frame_burst = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // Offer one header and record its expected result once it is taken.
  // Called and returns at a falling edge.
  task automatic send_frame(input frame_t f, input bit typed, input fwd_result_t typed_res);
    int unsigned gap;
    fwd_result_t pred;
    gap = frame_gap();
    if (gap > 0) begin
      frame_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    frame_if.valid   <= 1'b1;
    frame_if.src_mac <= f.src_mac;
    frame_if.dst_mac <= f.dst_mac;
    frame_if.in_port <= f.in_port;
    do @(posedge clk_i); while (!frame_if.ready);
    pred = forward_frame(f);
    fwd_expected_q.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  // One APB transfer, setup then access. Returns at a falling edge, with the select dropped.
  task automatic apb_access(input bit wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] wdata,
                            output logic [APB_DW-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drain the block, then write the port count and read it back.
  task automatic set_nports(input logic [PCNT_W-1:0] value);
    logic [APB_DW-1:0] rd;
    frame_if.valid <= 1'b0;
    while (fwd_expected_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    apb_access(1'b1, NPORTS_ADDR, APB_DW'(value), rd);
    apb_access(1'b0, NPORTS_ADDR, '0, rd);
    if (rd !== APB_DW'(value))
      note_mismatch($sformatf("port count readback: expected %0d, got %0h", value, rd));
    nports_q = value;
  endtask

  // Result receiver: random stalls, ready-high stretches, and one long
  // hold-off so that the block backs up into its input.
  initial begin
    int unsigned stall_left;
    int unsigned open_left;
    int unsigned r;
    bit          held;
    res_if.ready = 1'b0;
    stall_left   = 0;
    open_left    = 0;
    held         = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        res_if.ready <= 1'b0;
      end else if (!held && n_results >= HOLD_AT) begin
        held         = 1'b1;
        stall_left   = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else if (open_left > 0) begin
        open_left--;
        res_if.ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          open_left    = $urandom_range(20, 80);
          res_if.ready <= 1'b1;
        end else if (r < 33) begin
          stall_left   = $urandom_range(0, 3);
          res_if.ready <= 1'b0;
        end else if (r < 36) begin
          stall_left   = $urandom_range(10, 40);
          res_if.ready <= 1'b0;
        end else begin
          res_if.ready <= 1'b1;
        end
      end
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk_i) begin
    fwd_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      n_results++;
      if (fwd_expected_q.size() == 0) begin
        note_mismatch($sformatf("unexpected result: port %0d valid %0b hit %0b mask %04h",
                                res_if.egress_port, res_if.egress_valid,
                                res_if.table_hit, res_if.flood_mask));
      end else begin
        want = fwd_expected_q.pop_front();
        if (res_if.egress_port !== want.egress_port ||
            res_if.egress_valid !== want.egress_valid ||
            res_if.table_hit !== want.table_hit ||
            res_if.flood_mask !== want.flood_mask)
          note_mismatch($sformatf({"result %0d: expected port %0d valid %0b hit %0b mask %04h,",
                                   " got port %0d valid %0b hit %0b mask %04h"},
                                  n_results, want.egress_port, want.egress_valid,
                                  want.table_hit, want.flood_mask, res_if.egress_port,
                                  res_if.egress_valid, res_if.table_hit,
                                  res_if.flood_mask));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    n_cycles++;
    if (n_cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Main sequence: reset, directed frames, then random phases over a sweep
  // of port counts.
  initial begin
    logic [PCNT_W-1:0] sweep [8];
    fwd_result_t       typed_res;
    frame_t            f;
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    frame_if.valid   = 1'b0;
    frame_if.src_mac = '0;
    frame_if.dst_mac = '0;
    frame_if.in_port = '0;
    fdb_count        = 0;
    nports_q         = NPORTS_RST;
    n_mismatch       = 0;
    n_results        = 0;
    n_cycles         = 0;
    frame_burst      = 0;
    sweep            = '{5'd16, 5'd31, 5'd0, 5'd1, 5'd2, 5'd17, 5'd9, 5'd16};
    sweep[6]         = PCNT_W'($urandom_range(0, 31));
    foreach (mac_pool[i]) mac_pool[i] = random_mac();

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < N_DIRECTED; i++) begin
      if (DIRECTED[i].pcnt != nports_q) set_nports(DIRECTED[i].pcnt);
      f         = '{DIRECTED[i].src, DIRECTED[i].dst, DIRECTED[i].inp};
      typed_res = '{DIRECTED[i].eport, DIRECTED[i].evalid, DIRECTED[i].hit,
                    DIRECTED[i].mask};
      send_frame(f, DIRECTED[i].typed, typed_res);
    end

    for (int unsigned ph = 0; ph < 8; ph++) begin
      set_nports(sweep[ph]);
      repeat (PHASE_BEATS) send_frame(random_frame(), 1'b0, '0);
    end

    // Wait for the last results and a little beyond for strays.
    frame_if.valid <= 1'b0;
    while (fwd_expected_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (n_mismatch == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
